// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in
// scope and compiles to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds in that cycle
`define SHA1MD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1md assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1md assertion failed");

`else

`define SHA1MD_ASSERT_NOW(lbl, ante, cons)
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types and constants of the SHA-1 digest block: widths, initial chaining
// values, round constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 6;
  localparam int LEN_W    = 64;
  localparam int RND_W    = 7;
  localparam int IDX_W    = 3;
  localparam int NUM_H    = 5;
  localparam int NUM_W    = 16;

  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
  localparam logic [FILL_W-1:0] LEN_START = 6'd56;
  localparam logic [RND_W-1:0]  ROUND_LAST   = 7'd79;
  localparam logic [RND_W-1:0]  SCHED_DIRECT = 7'd16;
  localparam logic [RND_W-1:0]  PHASE_1      = 7'd20;
  localparam logic [RND_W-1:0]  PHASE_2      = 7'd40;
  localparam logic [RND_W-1:0]  PHASE_3      = 7'd60;
  localparam logic [IDX_W-1:0]  WORD_LAST    = 3'd4;
  localparam logic [BYTE_W-1:0] PAD_BYTE     = 8'h80;
  localparam logic [LEN_W-1:0]  BITS_PER_BYTE = 64'd8;

  localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] H_INIT [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Working variables of the compression
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Padding phase: marker byte, zero fill, length bytes
  typedef enum logic [1:0] {
    PM_MARK,
    PM_ZERO,
    PM_LEN
  } pad_mode_t;

endpackage

// File: hdl/sha1md_in_if.sv
// ----------------------------------------------------------------------------
// sha1md_in_if
// Message byte channel: valid/ready handshake with byte, presence and
// end-of-message flags.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
  import sha1md_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

// File: hdl/sha1md_out_if.sv
// ----------------------------------------------------------------------------
// sha1md_out_if
// Digest word channel: valid/ready handshake with one 32-bit digest word,
// its position and a last-word flag.
// ----------------------------------------------------------------------------
interface sha1md_out_if;
  import sha1md_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// File: hdl/sha1md_round.sv
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round: selects the round function and constant from the round
// number and produces the next working variables.
// ----------------------------------------------------------------------------
module sha1md_round (
  input  logic [sha1md_pkg::RND_W-1:0]  rnd,
  input  sha1md_pkg::work_t             cur,
  input  logic [sha1md_pkg::WORD_W-1:0] w,
  output sha1md_pkg::work_t             nxt
);
  import sha1md_pkg::*;

  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] k;
  logic [WORD_W-1:0] rot_a;

  // Pick function and constant for the current twenty-round phase
  always_comb begin
    if (rnd < PHASE_1) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K_0;
    end else if (rnd < PHASE_2) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_1;
    end else if (rnd < PHASE_3) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K_2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_3;
    end
  end

  assign rot_a = {cur.a[26:0], cur.a[31:27]};

  // Advance the working variables
  always_comb begin
    nxt.a = rot_a + f + cur.e + k + w;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// File: hdl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream. Bytes collect in a 16-word window that
// doubles as the message schedule; one shared round unit runs 80 times per
// block, and the final item triggers padding and five digest word transfers.
//
//   channel | dir | handshake        | payload
//   in_if   | in  | valid/ready      | data_byte, byte_present, end_of_message
//   out_if  | out | valid/ready      | digest_word, word_index, last_word
//
// Bytes are accepted while idle; the 64th byte of a block starts 80 rounds
// through the single round unit and a chaining add. The final item pushes the
// pad and length one byte per cycle, compressing each block filled, then
// offers five digest words, one per cycle while out_if.ready is high.
// in_if.ready is high only while idle. Reset is synchronous, active low, and
// leaves the initial chaining values with an empty message.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_message_digest (
  input logic          clk,
  input logic          rst_n,
  sha1md_in_if.sink    in_if,
  sha1md_out_if.source out_if
);
  import sha1md_pkg::*;

  state_t            state_r, state_nxt;
  pad_mode_t         mode_r, mode_nxt;
  logic [WORD_W-1:0] win_r [NUM_W];
  logic [WORD_W-1:0] h_r [NUM_H];
  work_t             wv_r, wv_nxt, h_work;
  logic [FILL_W-1:0] fill_r;
  logic [LEN_W-1:0]  bitcnt_r;
  logic [LEN_W-1:0]  len_r;
  logic [RND_W-1:0]  rnd_r;
  logic [IDX_W-1:0]  emit_idx_r;
  logic              pad_r;
  logic              done_r;

  logic              push_en;
  logic [BYTE_W-1:0] push_val;
  logic              msg_end;
  logic              len_push;
  logic              done_set;
  logic [BYTE_W-1:0] len_byte;
  logic [WORD_W-1:0] sched_x;
  logic [WORD_W-1:0] sched_w;
  logic              out_xfer;

  assign out_xfer = out_if.valid && out_if.ready;

  // Length byte for the current fill position, most significant first
  assign len_byte = len_r[LEN_W-1 - BYTE_W*fill_r[2:0] -: BYTE_W];
  assign len_push = (mode_r == PM_LEN) || ((mode_r == PM_ZERO) && (fill_r == LEN_START));
  assign done_set = (state_r == ST_PAD) && len_push && (fill_r == FILL_LAST);

  // Schedule word from the circular window
  assign sched_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched_w = (rnd_r < SCHED_DIRECT) ? win_r[0] : {sched_x[30:0], sched_x[31]};

  assign h_work = '{a: h_r[0], b: h_r[1], c: h_r[2], d: h_r[3], e: h_r[4]};

  sha1md_round u_round (
    .rnd (rnd_r),
    .cur (wv_r),
    .w   (sched_w),
    .nxt (wv_nxt)
  );

  // Sequencer: next state and byte push control
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    push_en   = 1'b0;
    push_val  = '0;
    msg_end   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          push_en  = in_if.byte_present;
          push_val = in_if.data_byte;
          if (in_if.end_of_message) begin
            msg_end   = 1'b1;
            mode_nxt  = PM_MARK;
            state_nxt = ST_PAD;
          end
          if (push_en && (fill_r == FILL_LAST)) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (done_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        case (mode_r)
          PM_MARK: begin
            push_val = PAD_BYTE;
            mode_nxt = PM_ZERO;
          end
          PM_ZERO: begin
            if (len_push) begin
              push_val = len_byte;
              mode_nxt = PM_LEN;
            end
          end
          PM_LEN: begin
            push_val = len_byte;
          end
          default: begin
            push_val = '0;
          end
        endcase
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (out_if.ready && (emit_idx_r == WORD_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= PM_MARK;
      fill_r     <= '0;
      bitcnt_r   <= '0;
      rnd_r      <= '0;
      emit_idx_r <= '0;
      pad_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      if (push_en) begin
        fill_r <= fill_r + 1'b1;
      end
      if ((state_r == ST_IDLE) && push_en) begin
        bitcnt_r <= bitcnt_r + BITS_PER_BYTE;
      end
      if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 1'b1;
      end else begin
        rnd_r <= '0;
      end
      if (msg_end) begin
        pad_r <= 1'b1;
      end
      if (done_set) begin
        done_r <= 1'b1;
      end
      if (out_xfer) begin
        if (emit_idx_r == WORD_LAST) begin
          emit_idx_r <= '0;
          bitcnt_r   <= '0;
          pad_r      <= 1'b0;
          done_r     <= 1'b0;
        end else begin
          emit_idx_r <= emit_idx_r + 1'b1;
        end
      end
    end
  end

  // Chaining words: add at block end, reload after the last transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_H; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else if (state_r == ST_ADD) begin
      h_r[0] <= h_r[0] + wv_r.a;
      h_r[1] <= h_r[1] + wv_r.b;
      h_r[2] <= h_r[2] + wv_r.c;
      h_r[3] <= h_r[3] + wv_r.d;
      h_r[4] <= h_r[4] + wv_r.e;
    end else if (out_xfer && (emit_idx_r == WORD_LAST)) begin
      for (int i = 0; i < NUM_H; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end
  end

  // Window: shift bytes in while filling, rotate schedule words during rounds
  always_ff @(posedge clk) begin
    if (push_en) begin
      for (int i = 0; i < NUM_W-1; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[NUM_W-1] <= {win_r[NUM_W-1][23:0], push_val};
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < NUM_W-1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[NUM_W-1] <= sched_w;
    end
  end

  // Working variables and message length latch
  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      wv_r <= wv_nxt;
    end else begin
      wv_r <= h_work;
    end
    if (msg_end) begin
      len_r <= in_if.byte_present ? (bitcnt_r + BITS_PER_BYTE) : bitcnt_r;
    end
  end

  // Port drive
  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = (state_r == ST_EMIT);
  assign out_if.digest_word = h_r[emit_idx_r];
  assign out_if.word_index  = emit_idx_r;
  assign out_if.last_word   = (emit_idx_r == WORD_LAST);

  // Checks
  `SHA1MD_ASSERT_NOW(a_no_overlap, in_if.ready, !out_if.valid)
  `SHA1MD_ASSERT_NEXT(a_round_to_add, rnd_r == ROUND_LAST, state_r == ST_ADD)
  `SHA1MD_ASSERT_NEXT(a_last_to_idle, out_xfer && out_if.last_word, in_if.ready && (fill_r == '0))
  `SHA1MD_ASSERT_NOW(a_emit_block_empty, out_if.valid, (fill_r == 6'd0) && done_r)

endmodule

// File: dv/tb_sha1_message_digest.sv
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// Self-checking bench for the byte-serial SHA-1 digest block. A queue of
// message items feeds a valid/ready driver. A clocked monitor runs every
// accepted item through a local SHA-1 predictor and checks each digest word
// transfer against the oldest predicted word. Both channels idle at random,
// and the result side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1md_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 12;
  localparam int TOTAL_ITEMS  = 155;
  localparam int BLOCK_BYTES  = 64;
  localparam int LEN_OFFSET   = 56;
  localparam int DIGEST_WORDS = 5;
  localparam logic [7:0]  MARK_BYTE = 8'h80;

  localparam logic [31:0] IV [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RC_0 = 32'h5A827999;
  localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC_3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              closes;
  } msg_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index;
    logic              last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst_n;

  sha1md_in_if  in_ch ();
  sha1md_out_if out_ch ();

  sha1_message_digest u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [31:0] chain [DIGEST_WORDS];
  logic [7:0]  blk [BLOCK_BYTES];
  int unsigned fill;
  logic [63:0] bit_len;

  msg_item_t    item_q [$];
  digest_word_t digest_q [$];
  digest_word_t exp_word;

  int mismatches    = 0;
  int msgs_closed   = 0;
  int bytes_hashed  = 0;
  int words_checked = 0;
  int results_seen  = 0;

  // Handshake bookkeeping between the clocked processes
  bit in_busy   = 1'b0;
  bit in_taken  = 1'b0;
  bit in_calm   = 1'b0;
  int in_gap    = 0;
  msg_item_t in_cur;

  bit out_taken = 1'b0;
  bit out_calm  = 1'b0;
  bit hold_done = 1'b0;
  int out_wait  = 0;
  int hold_left = 0;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic restart_digest();
    for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = IV[i];
    fill    = 0;
    bit_len = '0;
  endtask

  // Run the 80 rounds over the buffered block and fold into the chain
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = rotl(w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[r & 15], 1);
        w[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_2;
      end else begin
        f = b ^ c ^ d;
        k = RC_3;
      end
      tmp = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = tmp;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk[fill] = v;
    fill++;
    if (fill == BLOCK_BYTES) begin
      compress_block();
      fill = 0;
    end
  endtask

  // Update the digest with one accepted item; queue the words on a close
  task automatic hash_item(input msg_item_t it);
    logic [63:0]  len;
    digest_word_t dw;
    if (it.present) begin
      absorb_byte(it.data);
      bit_len = bit_len + 64'd8;
      bytes_hashed++;
    end
    if (it.closes) begin
      len = bit_len;
      absorb_byte(MARK_BYTE);
      while (fill != LEN_OFFSET) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        dw = '{chain[i], IDX_W'(i), i == DIGEST_WORDS - 1};
        digest_q = {digest_q, dw};
      end
      msgs_closed++;
      restart_digest();
    end
  endtask

  task automatic queue_item(input logic [7:0] d, input bit p, input bit c);
    msg_item_t it;
    it = '{d, p, c};
    item_q = {item_q, it};
  endtask

  // Queue a message of random bytes with idle items sprinkled in
  task automatic queue_message(input int len, input bit empty_close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
      queue_item(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
    end
    if (len == 0 || empty_close) queue_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Driver: present the next item at the falling edge after its gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy  = 1'b0;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 3);
      end
      if (!in_busy && in_gap == 0 && item_q.size() != 0) begin
        in_cur = item_q[0];
        item_q.delete(0);
        in_ch.data_byte      <= in_cur.data;
        in_ch.byte_present   <= in_cur.present;
        in_ch.end_of_message <= in_cur.closes;
        in_ch.valid          <= 1'b1;
        in_busy = 1'b1;
      end else if (!in_busy) begin
        if (in_gap > 0) in_gap--;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side ready: per-transfer waits plus one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 3);
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check digest transfers, feed accepted items to the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        out_taken = 1'b1;
        if (digest_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected digest word: expected none, got %h index %0d last %0b",
                   $time, out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end else begin
          exp_word = digest_q[0];
          digest_q.delete(0);
          words_checked++;
          if (out_ch.digest_word !== exp_word.word) begin
            mismatches++;
            $display("%0t: digest_word expected %h, got %h",
                     $time, exp_word.word, out_ch.digest_word);
          end
          if (out_ch.word_index !== exp_word.index) begin
            mismatches++;
            $display("%0t: word_index expected %0d, got %0d",
                     $time, exp_word.index, out_ch.word_index);
          end
          if (out_ch.last_word !== exp_word.last) begin
            mismatches++;
            $display("%0t: last_word expected %0b, got %0b",
                     $time, exp_word.last, out_ch.last_word);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        hash_item('{in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message});
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    restart_digest();

    // Empty message closed by an empty final item
    queue_item(8'hA5, 1'b0, 1'b1);
    // Three bytes, the last carried on the final item
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    // Same bytes, closed by an empty final item
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1);
    // Byte extremes with idle items in between
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'h80, 1'b1, 1'b1);
    // Idle item ahead of an empty message
    queue_item(8'h55, 1'b0, 1'b0);
    queue_item(8'hAA, 1'b0, 1'b1);
    // Single byte message
    queue_item(8'hFF, 1'b1, 1'b1);

    // Pad spilling into a second block, and a full data block
    queue_message(56, $urandom_range(0, 1));
    queue_message(64, $urandom_range(0, 1));

    // Short random messages up to the item budget
    while (item_q.size() < TOTAL_ITEMS) begin
      queue_message($urandom_range(0, 8), $urandom_range(0, 1));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (item_q.size() != 0 || in_busy) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages (%0d bytes), checked %0d digest words, long hold %0s.",
             msgs_closed, bytes_hashed, words_checked, hold_done ? "applied" : "not reached");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CYCLE_LIMIT * CLK_PERIOD);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/sha1md_pkg.sv
hdl/sha1md_in_if.sv
hdl/sha1md_out_if.sv
hdl/sha1md_round.sv
hdl/sha1_message_digest.sv
dv/tb_sha1_message_digest.sv
